[rtl/rlft_pkg.sv]
// ----------------------------------------------------------------------------
// rlft_pkg: shared types and constants of the run-length FIFO
// Store depth, derived widths, request kinds, status codes and the back-end
// sequencer states.
// ----------------------------------------------------------------------------
package rlft_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int HELD_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int SUM_W       = 64;

    // request queue between front and back
    localparam int FQ_DEPTH = 2;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_SHORT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_TAKE,
        CMD_TAKE_NONE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] count;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } back_state_t;

endpackage

[rtl/run_length_fifo_weighted_take.sv]
// ----------------------------------------------------------------------------
// run_length_fifo_weighted_take: run-length-encoded FIFO with weighted take
// A push request appends one run (value, copies); a take request removes
// copies from the head and answers with the sum of the removed values.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. A push goes from the request queue
// through IDLE and DONE to the result register; a take walks READ, CMP, MUL
// and ACC per run it touches (RAM read, compare and split, 32x32 multiply,
// 64-bit accumulate), so the head-run walk sets the rate of takes. Requests
// are processed one at a time; a two-entry request queue keeps accepting
// while a take walks. The store holds QUEUE_DEPTH runs and needs no clearing
// after reset. Status 1 marks a push dropped on a full store, status 2 a
// take that asked for more copies than were held (it returns all of them).
// ----------------------------------------------------------------------------
module run_length_fifo_weighted_take (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic [rlft_pkg::DATA_W-1:0] value,
    input  logic [rlft_pkg::DATA_W-1:0] count,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [rlft_pkg::SUM_W-1:0]  sum
);

    logic           q_valid;
    logic           q_pop;
    rlft_pkg::cmd_t q_cmd;

    rlft_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .value    (value),
        .count    (count),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    rlft_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .sum       (sum)
    );

endmodule

[rtl/rlft_ram.sv]
// ----------------------------------------------------------------------------
// rlft_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rlft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/rlft_front.sv]
// ----------------------------------------------------------------------------
// rlft_front: request intake
// Accepts requests, sorts them into push, take and empty take, and holds
// them in a short queue for the back end.
// ----------------------------------------------------------------------------
module rlft_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       action,
    input  logic [rlft_pkg::DATA_W-1:0] value,
    input  logic [rlft_pkg::DATA_W-1:0] count,
    output logic                       q_valid,
    output rlft_pkg::cmd_t             q_cmd,
    input  logic                       q_pop
);

    rlft_pkg::cmd_t                  entry_reg [rlft_pkg::FQ_DEPTH];
    logic [rlft_pkg::FQ_AW-1:0]      wr_ptr_reg;
    logic [rlft_pkg::FQ_AW-1:0]      wr_ptr_next;
    logic [rlft_pkg::FQ_AW-1:0]      rd_ptr_reg;
    logic [rlft_pkg::FQ_AW-1:0]      rd_ptr_next;
    logic [rlft_pkg::FQ_CW-1:0]      fill_reg;
    logic [rlft_pkg::FQ_CW-1:0]      fill_next;
    rlft_pkg::cmd_t                  in_cmd;
    logic                            push_en;
    logic                            pop_en;

    always_comb
    begin
        in_cmd.value = value;
        in_cmd.count = count;
        if (!action)
        begin
            in_cmd.kind = rlft_pkg::CMD_PUSH;
        end
        else if (count == '0)
        begin
            in_cmd.kind = rlft_pkg::CMD_TAKE_NONE;
        end
        else
        begin
            in_cmd.kind = rlft_pkg::CMD_TAKE;
        end
    end

    assign in_stall = (fill_reg == rlft_pkg::FQ_CW'(rlft_pkg::FQ_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_cmd    = entry_reg[rd_ptr_reg];
    assign push_en  = in_valid && !in_stall;
    assign pop_en   = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push_en)
        begin
            wr_ptr_next = (wr_ptr_reg == rlft_pkg::FQ_AW'(rlft_pkg::FQ_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_en)
        begin
            rd_ptr_next = (rd_ptr_reg == rlft_pkg::FQ_AW'(rlft_pkg::FQ_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push_en, pop_en})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[rtl/rlft_back.sv]
// ----------------------------------------------------------------------------
// rlft_back: run store and take sequencer
// Holds the runs in two RAMs, appends pushes at the tail and walks takes
// over the head runs one at a time, accumulating value times copies.
// ----------------------------------------------------------------------------
module rlft_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  rlft_pkg::cmd_t             q_cmd,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 status,
    output logic [rlft_pkg::SUM_W-1:0] sum
);

    rlft_pkg::back_state_t            state_reg;
    rlft_pkg::back_state_t            state_next;
    logic [rlft_pkg::IDX_W-1:0]       head_reg;
    logic [rlft_pkg::IDX_W-1:0]       head_next;
    logic [rlft_pkg::IDX_W-1:0]       tail_reg;
    logic [rlft_pkg::IDX_W-1:0]       tail_next;
    logic [rlft_pkg::HELD_W-1:0]      held_reg;
    logic [rlft_pkg::HELD_W-1:0]      held_next;
    logic [rlft_pkg::DATA_W-1:0]      want_reg;
    logic [rlft_pkg::DATA_W-1:0]      want_next;
    logic [rlft_pkg::DATA_W-1:0]      take_n_reg;
    logic [rlft_pkg::DATA_W-1:0]      take_n_next;
    logic [rlft_pkg::SUM_W-1:0]       product_reg;
    logic [rlft_pkg::SUM_W-1:0]       product_next;
    logic [rlft_pkg::SUM_W-1:0]       total_reg;
    logic [rlft_pkg::SUM_W-1:0]       total_next;
    rlft_pkg::status_t                res_status_reg;
    rlft_pkg::status_t                res_status_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    rlft_pkg::status_t                out_status_reg;
    rlft_pkg::status_t                out_status_next;
    logic [rlft_pkg::SUM_W-1:0]       out_sum_reg;
    logic [rlft_pkg::SUM_W-1:0]       out_sum_next;

    logic                             store_full;
    logic                             out_free;
    logic                             val_we;
    logic                             cnt_we;
    logic [rlft_pkg::IDX_W-1:0]       cnt_waddr;
    logic [rlft_pkg::DATA_W-1:0]      cnt_wdata;
    logic                             rd_en;
    logic [rlft_pkg::DATA_W-1:0]      val_rdata;
    logic [rlft_pkg::DATA_W-1:0]      cnt_rdata;

    assign store_full = (held_reg == rlft_pkg::HELD_W'(rlft_pkg::QUEUE_DEPTH));
    assign out_free   = !out_valid_reg || !out_stall;

    rlft_ram #(
        .WIDTH (rlft_pkg::DATA_W),
        .DEPTH (rlft_pkg::QUEUE_DEPTH)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (tail_reg),
        .wdata (q_cmd.value),
        .re    (rd_en),
        .raddr (head_reg),
        .rdata (val_rdata)
    );

    rlft_ram #(
        .WIDTH (rlft_pkg::DATA_W),
        .DEPTH (rlft_pkg::QUEUE_DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (rd_en),
        .raddr (head_reg),
        .rdata (cnt_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rlft_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.kind == rlft_pkg::CMD_TAKE && held_reg != '0)
                    begin
                        state_next = rlft_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = rlft_pkg::ST_DONE;
                    end
                end
            end
            rlft_pkg::ST_READ: state_next = rlft_pkg::ST_CMP;
            rlft_pkg::ST_CMP:  state_next = rlft_pkg::ST_MUL;
            rlft_pkg::ST_MUL:  state_next = rlft_pkg::ST_ACC;
            rlft_pkg::ST_ACC:
            begin
                if (want_reg == '0 || held_reg == '0)
                begin
                    state_next = rlft_pkg::ST_DONE;
                end
                else
                begin
                    state_next = rlft_pkg::ST_READ;
                end
            end
            rlft_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = rlft_pkg::ST_IDLE;
                end
            end
            default: state_next = rlft_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        held_next       = held_reg;
        want_next       = want_reg;
        take_n_next     = take_n_reg;
        product_next    = product_reg;
        total_next      = total_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_sum_next    = out_sum_reg;
        q_pop           = 1'b0;
        val_we          = 1'b0;
        cnt_we          = 1'b0;
        cnt_waddr       = tail_reg;
        cnt_wdata       = q_cmd.count;
        rd_en           = 1'b0;
        case (state_reg)
            rlft_pkg::ST_IDLE:
            begin
                q_pop           = q_valid;
                total_next      = '0;
                want_next       = q_cmd.count;
                res_status_next = rlft_pkg::STATUS_OK;
                if (q_valid)
                begin
                    case (q_cmd.kind)
                        rlft_pkg::CMD_PUSH:
                        begin
                            if (store_full)
                            begin
                                res_status_next = rlft_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                val_we    = 1'b1;
                                cnt_we    = 1'b1;
                                tail_next = (tail_reg == rlft_pkg::IDX_W'(rlft_pkg::QUEUE_DEPTH - 1))
                                          ? '0 : tail_reg + 1'b1;
                                held_next = held_reg + 1'b1;
                            end
                        end
                        rlft_pkg::CMD_TAKE:
                        begin
                            if (held_reg == '0)
                            begin
                                res_status_next = rlft_pkg::STATUS_SHORT;
                            end
                        end
                        default:
                        begin
                            res_status_next = rlft_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            rlft_pkg::ST_READ:
            begin
                rd_en = 1'b1;
            end
            rlft_pkg::ST_CMP:
            begin
                if (want_reg >= cnt_rdata)
                begin
                    // consume the whole head run
                    take_n_next = cnt_rdata;
                    want_next   = want_reg - cnt_rdata;
                    head_next   = (head_reg == rlft_pkg::IDX_W'(rlft_pkg::QUEUE_DEPTH - 1))
                                ? '0 : head_reg + 1'b1;
                    held_next   = held_reg - 1'b1;
                end
                else
                begin
                    // split: leave the remainder at the head
                    take_n_next = want_reg;
                    want_next   = '0;
                    cnt_we      = 1'b1;
                    cnt_waddr   = head_reg;
                    cnt_wdata   = cnt_rdata - want_reg;
                end
            end
            rlft_pkg::ST_MUL:
            begin
                product_next = rlft_pkg::SUM_W'(val_rdata) * rlft_pkg::SUM_W'(take_n_reg);
            end
            rlft_pkg::ST_ACC:
            begin
                total_next = total_reg + product_reg;
                if (want_reg != '0 && held_reg == '0)
                begin
                    res_status_next = rlft_pkg::STATUS_SHORT;
                end
            end
            rlft_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_sum_next    = total_reg;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rlft_pkg::ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg       <= want_next;
        take_n_reg     <= take_n_next;
        product_reg    <= product_next;
        total_reg      <= total_next;
        res_status_reg <= res_status_next;
        out_status_reg <= out_status_next;
        out_sum_reg    <= out_sum_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign sum       = out_sum_reg;

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= rlft_pkg::HELD_W'(rlft_pkg::QUEUE_DEPTH))
        else $error("run count exceeds store depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty store with head and tail apart");

    a_cmp_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlft_pkg::ST_CMP) |-> (held_reg != '0))
        else $error("head run read from an empty store");

    a_walk_on: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlft_pkg::ST_ACC && want_reg != '0 && held_reg != '0)
        |=> (state_reg == rlft_pkg::ST_READ))
        else $error("take stopped with copies wanted and runs held");

endmodule

[test/run_length_fifo_weighted_take_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// run_length_fifo_weighted_take_checker: scoreboard for the run-length FIFO
// Watches both channels and keeps its own copy of the run store. Each
// accepted request is predicted and the answer is queued. Each accepted
// result is compared with the oldest queued answer.
// ----------------------------------------------------------------------------
module run_length_fifo_weighted_take_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        action,
    input  logic [rlft_pkg::DATA_W-1:0] value,
    input  logic [rlft_pkg::DATA_W-1:0] count,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [1:0]                  status,
    input  logic [rlft_pkg::SUM_W-1:0]  sum,
    output int                          errors,
    output int                          pending
);

    import rlft_pkg::*;

    typedef struct packed {
        status_t          code;
        logic [SUM_W-1:0] total;
    } answer_t;

    logic [DATA_W-1:0] run_val [QUEUE_DEPTH];
    logic [DATA_W-1:0] run_cnt [QUEUE_DEPTH];
    logic [IDX_W-1:0]  head_slot;
    logic [IDX_W-1:0]  tail_slot;
    logic [HELD_W-1:0] runs_in_store;
    answer_t           answers_due [$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
        if (int'(slot) == QUEUE_DEPTH - 1)
            return '0;
        return slot + 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
                                   input logic [SUM_W-1:0] want);
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    // update the store copy with one request and work out its answer
    task automatic compute_answer(input logic act, input logic [DATA_W-1:0] v,
                                  input logic [DATA_W-1:0] c, output answer_t ans);
        logic [DATA_W-1:0] want;
        logic [DATA_W-1:0] copies;
        ans.code  = STATUS_OK;
        ans.total = '0;
        if (act == 1'(CMD_PUSH))
        begin
            if (int'(runs_in_store) >= QUEUE_DEPTH)
                ans.code = STATUS_FULL;
            else
            begin
                run_val[tail_slot] = v;
                run_cnt[tail_slot] = c;
                tail_slot          = next_slot(tail_slot);
                runs_in_store++;
            end
        end
        else
        begin
            want = c;
            while (want != 0)
            begin
                if (runs_in_store == 0)
                begin
                    ans.code = STATUS_SHORT;
                    want     = 0;
                end
                else
                begin
                    copies = run_cnt[head_slot];
                    if (want >= copies)
                    begin
                        // consume the whole head run
                        ans.total += {32'd0, run_val[head_slot]} * {32'd0, copies};
                        want      -= copies;
                        head_slot  = next_slot(head_slot);
                        runs_in_store--;
                    end
                    else
                    begin
                        // split the head run, keep the remainder
                        ans.total += {32'd0, run_val[head_slot]} * {32'd0, want};
                        run_cnt[head_slot] = copies - want;
                        want = 0;
                    end
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t ans;
        if (!rst_n)
        begin
            head_slot     = '0;
            tail_slot     = '0;
            runs_in_store = '0;
            answers_due.delete();
            pending = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                compute_answer(action, value, count, ans);
                answers_due = {answers_due, ans};
            end
            if (out_valid && !out_stall)
            begin
                if (answers_due.size() == 0)
                    report_mismatch("result with no request pending", sum, '0);
                else
                begin
                    ans = answers_due[0];
                    answers_due.delete(0);
                    if (status !== ans.code)
                        report_mismatch("status", 64'(status), 64'(ans.code));
                    if (sum !== ans.total)
                        report_mismatch("sum", sum, ans.total);
                end
            end
            pending = answers_due.size();
        end
    end

endmodule

[test/tb_run_length_fifo_weighted_take.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_run_length_fifo_weighted_take: testbench of the run-length FIFO
// Drives directed push and take requests, then random traffic under three
// idling patterns, including a fill past capacity and a full drain. A
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_run_length_fifo_weighted_take;

    import rlft_pkg::*;

    // the action bit is the low bit of the request kind
    localparam logic ACT_PUSH = 1'(CMD_PUSH);
    localparam logic ACT_TAKE = 1'(CMD_TAKE);

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              action;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] count;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        status;
    logic [SUM_W-1:0]  sum;
    int                errors;
    int                pending;
    int                send_idle_pct;
    int                recv_idle_pct;

    run_length_fifo_weighted_take uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .value     (value),
        .count     (count),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .sum       (sum)
    );

    run_length_fifo_weighted_take_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .value     (value),
        .count     (count),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .sum       (sum),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    task automatic send_request(input logic act, input logic [DATA_W-1:0] v,
                                input logic [DATA_W-1:0] c);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        value    <= v;
        count    <= c;
        // hold the request until it is accepted
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic push_run(input logic [DATA_W-1:0] v, input logic [DATA_W-1:0] c);
        send_request(ACT_PUSH, v, c);
    endtask

    task automatic take_copies(input logic [DATA_W-1:0] c);
        send_request(ACT_TAKE, $urandom, c);
    endtask

    task automatic random_request();
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] c;
        int                roll;
        roll = $urandom_range(99);
        if ($urandom_range(99) < 50)
        begin
            case ($urandom_range(3))
                0: v = $urandom_range(15);
                1: v = '1;
                default: v = $urandom;
            endcase
            if (roll < 5)
                c = $urandom;
            else if (roll < 25)
                c = $urandom_range(1000);
            else
                c = $urandom_range(8);
            push_run(v, c);
        end
        else
        begin
            if (roll < 6)
                c = $urandom;
            else if (roll < 9)
                c = '1;
            else if (roll < 24)
                c = $urandom_range(2000);
            else
                c = $urandom_range(12);
            take_copies(c);
        end
    endtask

    initial
    begin
        in_valid      = 1'b0;
        action        = ACT_PUSH;
        value         = '0;
        count         = '0;
        out_stall     = 1'b0;
        rst_n         = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 64;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // empty store: short take, then a zero take
        take_copies(1);
        take_copies(0);
        // zero-copy run ahead of extreme and split runs
        push_run('0, '0);
        push_run('1, '1);
        push_run(5, 3);
        take_copies(0);
        take_copies(1);
        take_copies('1);
        take_copies(10);
        // exact take over two runs
        push_run(32'hA5A5_A5A5, 1);
        push_run(32'h5A5A_5A5A, 2);
        take_copies(3);
        // zero take leaves a zero-copy run, a larger take runs short past it
        push_run(7, 0);
        take_copies(0);
        take_copies(5);
        push_run(1, 1);
        take_copies(1);
        push_run('1, 32'h8000_0000);
        push_run(32'h8000_0000, 32'h7FFF_FFFF);
        take_copies(32'h8000_0001);
        take_copies(32'h7FFF_FFFF);

        repeat (250) random_request();

        send_idle_pct = 64;
        recv_idle_pct = 18;
        repeat (250) random_request();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // overfill so that several pushes hit a full store, then drain
        repeat (QUEUE_DEPTH + 12) push_run($urandom, $urandom_range(3));
        take_copies('1);
        take_copies('1);
        take_copies('1);
        take_copies($urandom_range(50));
        repeat (150) random_request();

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
